// ===== hdl/dhkrp_pkg.sv =====
// Shared types and constants for the DH public key record parser.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package dhkrp_pkg;

    // Section tags on the result channel
    localparam logic [3:0] SEC_PLEN    = 4'd0;
    localparam logic [3:0] SEC_SPEC_ID = 4'd1;
    localparam logic [3:0] SEC_PRIME   = 4'd2;
    localparam logic [3:0] SEC_GLEN    = 4'd3;
    localparam logic [3:0] SEC_GEN     = 4'd4;
    localparam logic [3:0] SEC_PUBLEN  = 4'd5;
    localparam logic [3:0] SEC_PUBLIC  = 4'd6;
    localparam logic [3:0] SEC_TRAIL   = 4'd7;
    localparam logic [3:0] SEC_NONE    = 4'd8;

    // End-of-record status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Smallest explicit prime length in bytes
    localparam logic [15:0] MIN_PRIME_LEN = 16'd16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // One pre-decoded record item as it sits in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic [3:0] byte_bits;  // position of the leading one, 0 for a zero byte
        logic       is_two;
    } item_t;

    // One result item
    typedef struct packed {
        logic [3:0]  section;
        logic [7:0]  out_byte;
        logic        done_res;
        logic [1:0]  status;
        logic [18:0] key_bits;
        logic [1:0]  special_prime;
        logic [15:0] prime_len;
        logic [15:0] gen_len;
        logic [15:0] pub_len;
    } result_t;

    // Bit length of the well-known primes by id
    function automatic logic [18:0] special_bits(input logic [1:0] id);
        logic [18:0] r;
        case (id)
            2'd1:    r = 19'd768;
            2'd2:    r = 19'd1024;
            2'd3:    r = 19'd1536;
            default: r = 19'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dhkrp_front.sv =====
// Front end: takes input transfers and pre-decodes each byte for the back end.
// Depends on dhkrp_pkg.
`default_nettype none

module dhkrp_front (
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_data_byte,
    input  wire logic            s_has_byte,
    input  wire logic            s_last,
    input  wire logic            queue_full,
    output logic                 push,
    output dhkrp_pkg::item_t     push_item
);

    // Leading-one position of a byte (0 for zero)
    function automatic logic [3:0] lead_one(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) n = 4'(i + 1);
        end
        return n;
    endfunction

    // Accept whenever the queue has room
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // Classification of the incoming byte
    always_comb begin
        push_item.data_byte = s_data_byte;
        push_item.has_byte  = s_has_byte;
        push_item.last      = s_last;
        push_item.byte_bits = lead_one(s_data_byte);
        push_item.is_two    = (s_data_byte == 8'd2);
    end

endmodule

`default_nettype wire

// ===== hdl/dhkrp_queue.sv =====
// Two-entry queue of pre-decoded items between front and back.
// Depends on dhkrp_pkg.
`default_nettype none

module dhkrp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire dhkrp_pkg::item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output dhkrp_pkg::item_t      pop_item,
    output logic                  not_empty
);

    dhkrp_pkg::item_t                 mem_reg [dhkrp_pkg::QUEUE_DEPTH];
    logic [dhkrp_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dhkrp_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dhkrp_pkg::QUEUE_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == dhkrp_pkg::QUEUE_CW'(dhkrp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== hdl/dhkrp_back.sv =====
// Back end: record parser state machine and the result register.
// Depends on dhkrp_pkg.
`default_nettype none

module dhkrp_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             item_valid,
    input  wire dhkrp_pkg::item_t item,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dhkrp_pkg::result_t    result
);

    localparam logic [3:0] PH_PLEN_HI = 4'd0;
    localparam logic [3:0] PH_PLEN_LO = 4'd1;
    localparam logic [3:0] PH_SPEC    = 4'd2;
    localparam logic [3:0] PH_PRIME   = 4'd3;
    localparam logic [3:0] PH_GLEN_HI = 4'd4;
    localparam logic [3:0] PH_GLEN_LO = 4'd5;
    localparam logic [3:0] PH_GEN     = 4'd6;
    localparam logic [3:0] PH_PLN_HI  = 4'd7;
    localparam logic [3:0] PH_PLN_LO  = 4'd8;
    localparam logic [3:0] PH_PUB     = 4'd9;
    localparam logic [3:0] PH_TRAIL   = 4'd10;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] prime_length_reg, prime_length_next;
    logic [15:0] gen_length_reg, gen_length_next;
    logic [15:0] pub_length_reg, pub_length_next;
    logic [15:0] special_id_reg, special_id_next;
    logic [18:0] bit_count_reg, bit_count_next;
    logic        gen_bad_reg, gen_bad_next;
    logic        error_seen_reg, error_seen_next;
    logic        any_byte_reg, any_byte_next;

    logic               m_valid_reg, m_valid_next;
    dhkrp_pkg::result_t result_reg, result_next;

    logic [15:0] rem_dec;
    logic [15:0] plen_full, glen_full, plnlen_full;
    logic        plen_special, cur_special;
    logic [1:0]  st;

    // Take the next item when the result register is free or draining
    assign pop     = item_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    assign rem_dec      = remaining_reg - 16'd1;
    assign plen_full    = prime_length_reg | {8'h00, item.data_byte};
    assign glen_full    = gen_length_reg | {8'h00, item.data_byte};
    assign plnlen_full  = pub_length_reg | {8'h00, item.data_byte};
    assign plen_special = (plen_full == 16'd1) || (plen_full == 16'd2);
    assign cur_special  = (prime_length_reg == 16'd1) || (prime_length_reg == 16'd2);

    // Per-byte parse step and end-of-record summary
    always_comb begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        prime_length_next = prime_length_reg;
        gen_length_next   = gen_length_reg;
        pub_length_next   = pub_length_reg;
        special_id_next   = special_id_reg;
        bit_count_next    = bit_count_reg;
        gen_bad_next      = gen_bad_reg;
        error_seen_next   = error_seen_reg;
        any_byte_next     = any_byte_reg;
        result_next       = '0;
        result_next.section = dhkrp_pkg::SEC_NONE;
        st                = dhkrp_pkg::ST_OK;

        if (item.has_byte) begin
            any_byte_next        = 1'b1;
            result_next.out_byte = item.data_byte;
            if (!error_seen_reg && !gen_bad_reg) begin
                case (phase_reg)
                    PH_PLEN_HI: begin
                        prime_length_next   = {item.data_byte, 8'h00};
                        phase_next          = PH_PLEN_LO;
                        result_next.section = dhkrp_pkg::SEC_PLEN;
                    end
                    PH_PLEN_LO: begin
                        prime_length_next   = plen_full;
                        result_next.section = dhkrp_pkg::SEC_PLEN;
                        if (plen_special) begin
                            remaining_next  = plen_full;
                            special_id_next = '0;
                            phase_next      = PH_SPEC;
                        end else if (plen_full < dhkrp_pkg::MIN_PRIME_LEN) begin
                            error_seen_next = 1'b1;
                        end else begin
                            remaining_next = plen_full;
                            bit_count_next = '0;
                            phase_next     = PH_PRIME;
                        end
                    end
                    PH_SPEC: begin
                        special_id_next     = {special_id_reg[7:0], item.data_byte};
                        remaining_next      = rem_dec;
                        result_next.section = dhkrp_pkg::SEC_SPEC_ID;
                        if (rem_dec == '0) begin
                            if (special_id_next >= 16'd1 && special_id_next <= 16'd3) begin
                                bit_count_next =
                                    dhkrp_pkg::special_bits(special_id_next[1:0]);
                                phase_next = PH_GLEN_HI;
                            end else begin
                                error_seen_next = 1'b1;
                            end
                        end
                    end
                    PH_PRIME: begin
                        // first nonzero byte fixes the significant bit count
                        if (bit_count_reg == '0 && item.byte_bits != 4'd0) begin
                            bit_count_next = {rem_dec, 3'b000} + {15'd0, item.byte_bits};
                        end
                        remaining_next      = rem_dec;
                        result_next.section = dhkrp_pkg::SEC_PRIME;
                        if (rem_dec == '0) phase_next = PH_GLEN_HI;
                    end
                    PH_GLEN_HI: begin
                        gen_length_next     = {item.data_byte, 8'h00};
                        phase_next          = PH_GLEN_LO;
                        result_next.section = dhkrp_pkg::SEC_GLEN;
                    end
                    PH_GLEN_LO: begin
                        gen_length_next     = glen_full;
                        result_next.section = dhkrp_pkg::SEC_GLEN;
                        if (cur_special) begin
                            if (glen_full == 16'd0) begin
                                phase_next = PH_PLN_HI;
                            end else if (glen_full == 16'd1) begin
                                remaining_next = 16'd1;
                                phase_next     = PH_GEN;
                            end else begin
                                error_seen_next = 1'b1;
                            end
                        end else if (glen_full == 16'd0) begin
                            error_seen_next = 1'b1;
                        end else begin
                            remaining_next = glen_full;
                            phase_next     = PH_GEN;
                        end
                    end
                    PH_GEN: begin
                        if (cur_special && !item.is_two) gen_bad_next = 1'b1;
                        remaining_next      = rem_dec;
                        result_next.section = dhkrp_pkg::SEC_GEN;
                        if (rem_dec == '0) phase_next = PH_PLN_HI;
                    end
                    PH_PLN_HI: begin
                        pub_length_next     = {item.data_byte, 8'h00};
                        phase_next          = PH_PLN_LO;
                        result_next.section = dhkrp_pkg::SEC_PUBLEN;
                    end
                    PH_PLN_LO: begin
                        pub_length_next     = plnlen_full;
                        result_next.section = dhkrp_pkg::SEC_PUBLEN;
                        if (plnlen_full == 16'd0) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            remaining_next = plnlen_full;
                            phase_next     = PH_PUB;
                        end
                    end
                    PH_PUB: begin
                        remaining_next      = rem_dec;
                        result_next.section = dhkrp_pkg::SEC_PUBLIC;
                        if (rem_dec == '0) phase_next = PH_TRAIL;
                    end
                    PH_TRAIL: begin
                        result_next.section = dhkrp_pkg::SEC_TRAIL;
                    end
                    default: begin
                        error_seen_next = 1'b1;
                    end
                endcase
            end
        end

        // End of record: report and return to the reset state
        if (item.last) begin
            if (!any_byte_next) begin
                st = dhkrp_pkg::ST_EMPTY;
            end else if (error_seen_next || gen_bad_next || phase_next != PH_TRAIL) begin
                st = dhkrp_pkg::ST_INVALID;
            end else begin
                st = dhkrp_pkg::ST_OK;
            end
            result_next.done_res = 1'b1;
            result_next.status   = st;
            if (st == dhkrp_pkg::ST_OK) begin
                result_next.key_bits  = bit_count_next;
                result_next.prime_len = prime_length_next;
                result_next.gen_len   = gen_length_next;
                result_next.pub_len   = pub_length_next;
                if ((prime_length_next == 16'd1) || (prime_length_next == 16'd2)) begin
                    result_next.special_prime = special_id_next[1:0];
                end
            end
            phase_next        = PH_PLEN_HI;
            remaining_next    = '0;
            prime_length_next = '0;
            gen_length_next   = '0;
            pub_length_next   = '0;
            special_id_next   = '0;
            bit_count_next    = '0;
            gen_bad_next      = 1'b0;
            error_seen_next   = 1'b0;
            any_byte_next     = 1'b0;
        end
    end

    // Output valid
    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Parser state, advanced once per popped item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_PLEN_HI;
            remaining_reg    <= '0;
            prime_length_reg <= '0;
            gen_length_reg   <= '0;
            pub_length_reg   <= '0;
            special_id_reg   <= '0;
            bit_count_reg    <= '0;
            gen_bad_reg      <= 1'b0;
            error_seen_reg   <= 1'b0;
            any_byte_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg        <= phase_next;
                remaining_reg    <= remaining_next;
                prime_length_reg <= prime_length_next;
                gen_length_reg   <= gen_length_next;
                pub_length_reg   <= pub_length_next;
                special_id_reg   <= special_id_next;
                bit_count_reg    <= bit_count_next;
                gen_bad_reg      <= gen_bad_next;
                error_seen_reg   <= error_seen_next;
                any_byte_reg     <= any_byte_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop) result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== hdl/dh_key_record_parser_core.sv =====
// Top level of the DH public key record parser: front end, queue, back end.
// Depends on dhkrp_pkg, dhkrp_front, dhkrp_queue and dhkrp_back.
`default_nettype none

// Streaming parser for a Diffie-Hellman public key record, one byte per
// transfer. Every input transfer yields exactly one result transfer that tags
// the byte with its record section; the transfer with s_last set also carries
// the status and, for an accepted record, the prime's significant bit count
// and the three length fields. Sustained rate is one item per clock while
// m_ready stays high: the back end's phase/counter update is combinational.
// Each item is written into the two-entry queue at the transfer edge and
// moves into the result register, raising m_valid, when the back end pops it.
// The input side keeps accepting while a result waits on m_ready until the
// queue holds two items.
module dh_key_record_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_section,
    output logic [7:0]       m_out_byte,
    output logic             m_done_res,
    output logic [1:0]       m_status,
    output logic [18:0]      m_key_bits,
    output logic [1:0]       m_special_prime,
    output logic [15:0]      m_prime_len,
    output logic [15:0]      m_gen_len,
    output logic [15:0]      m_pub_len
);

    logic               queue_full;
    logic               push;
    dhkrp_pkg::item_t   push_item;
    logic               pop;
    dhkrp_pkg::item_t   pop_item;
    logic               queue_not_empty;
    dhkrp_pkg::result_t result;

    dhkrp_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_has_byte  (s_has_byte),
        .s_last      (s_last),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    dhkrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    dhkrp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_not_empty),
        .item       (pop_item),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    // Result fields to ports
    assign m_section       = result.section;
    assign m_out_byte      = result.out_byte;
    assign m_done_res      = result.done_res;
    assign m_status        = result.status;
    assign m_key_bits      = result.key_bits;
    assign m_special_prime = result.special_prime;
    assign m_prime_len     = result.prime_len;
    assign m_gen_len       = result.gen_len;
    assign m_pub_len       = result.pub_len;

endmodule

`default_nettype wire

// ===== hdl/dhkrp_checker.sv =====
// Port-level checks on the result channel of dh_key_record_parser_core.
// Depends on dhkrp_pkg; bound to the top level at the end of this file.
`default_nettype none

module dhkrp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_section,
    input wire logic [7:0]  m_out_byte,
    input wire logic        m_done_res,
    input wire logic [1:0]  m_status,
    input wire logic [18:0] m_key_bits,
    input wire logic [1:0]  m_special_prime,
    input wire logic [15:0] m_prime_len,
    input wire logic [15:0] m_gen_len,
    input wire logic [15:0] m_pub_len
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_section) && $stable(m_out_byte)
            && $stable(m_done_res) && $stable(m_status) && $stable(m_key_bits))
        else $error("result changed while stalled");

    // Summary fields are zero away from the end of a record
    a_mid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == dhkrp_pkg::ST_OK && m_key_bits == '0
            && m_special_prime == '0 && m_prime_len == '0 && m_gen_len == '0
            && m_pub_len == '0)
        else $error("summary set on a mid-record transfer");

    // A failed or empty record reports no summary
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res && m_status != dhkrp_pkg::ST_OK |-> m_key_bits == '0
            && m_special_prime == '0 && m_prime_len == '0 && m_gen_len == '0
            && m_pub_len == '0)
        else $error("summary set on a rejected record");

    // Well-known primes carry their fixed size and a short length field
    a_special: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_special_prime != 2'd0 |->
            m_key_bits == dhkrp_pkg::special_bits(m_special_prime)
            && (m_prime_len == 16'd1 || m_prime_len == 16'd2) && m_gen_len <= 16'd1)
        else $error("well-known prime summary inconsistent");

    // Section tag stays in range
    a_section: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_section <= dhkrp_pkg::SEC_NONE)
        else $error("section tag out of range");

endmodule

bind dh_key_record_parser_core dhkrp_checker u_dhkrp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_section       (m_section),
    .m_out_byte      (m_out_byte),
    .m_done_res      (m_done_res),
    .m_status        (m_status),
    .m_key_bits      (m_key_bits),
    .m_special_prime (m_special_prime),
    .m_prime_len     (m_prime_len),
    .m_gen_len       (m_gen_len),
    .m_pub_len       (m_pub_len)
);

`default_nettype wire

// ===== bench/dh_key_record_parser_core_check.sv =====
`timescale 1ns / 1ps
// Result checker for dh_key_record_parser_core: watches both channels, predicts the
// tagged result of each input transfer and compares it with what the block returns.
// Depends on dhkrp_pkg for the section and status codes and the result layout.

module dh_key_record_parser_core_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [3:0]  m_section,
    input  wire logic [7:0]  m_out_byte,
    input  wire logic        m_done_res,
    input  wire logic [1:0]  m_status,
    input  wire logic [18:0] m_key_bits,
    input  wire logic [1:0]  m_special_prime,
    input  wire logic [15:0] m_prime_len,
    input  wire logic [15:0] m_gen_len,
    input  wire logic [15:0] m_pub_len,
    output int               fail_count,
    output int               outstanding
);

    // Parser position within the record
    typedef enum logic [3:0] {
        PH_PLEN_HI, PH_PLEN_LO, PH_SPEC, PH_PRIME, PH_GLEN_HI, PH_GLEN_LO,
        PH_GEN, PH_PUBLEN_HI, PH_PUBLEN_LO, PH_PUB, PH_TRAIL
    } parse_phase_e;

    // Well-known prime ids and the only generator allowed with them
    localparam logic [15:0] ID_P768     = 16'd1;
    localparam logic [15:0] ID_P1024    = 16'd2;
    localparam logic [15:0] ID_P1536    = 16'd3;
    localparam logic [7:0]  SPECIAL_GEN = 8'd2;

    parse_phase_e phase;
    logic [15:0]  left;
    logic [15:0]  plen;
    logic [15:0]  glen;
    logic [15:0]  publen;
    logic [15:0]  spec_id;
    logic [19:0]  prime_bits;
    logic         gen_bad;
    logic         rec_error;
    logic         seen_byte;

    dhkrp_pkg::result_t pending_tags[$];
    dhkrp_pkg::result_t got;
    dhkrp_pkg::result_t want;
    string        diff;
    int           res_count;

    function automatic void clear_parse();
        phase      = PH_PLEN_HI;
        left       = '0;
        plen       = '0;
        glen       = '0;
        publen     = '0;
        spec_id    = '0;
        prime_bits = '0;
        gen_bad    = 1'b0;
        rec_error  = 1'b0;
        seen_byte  = 1'b0;
    endfunction

    function automatic logic special_len();
        return (plen == 16'd1) || (plen == 16'd2);
    endfunction

    // Expected result of one input transfer; advances the parse state
    function automatic dhkrp_pkg::result_t parse_item(input logic [7:0] b, input logic has,
                                                      input logic last);
        dhkrp_pkg::result_t r;
        int      lead;
        int      i;
        r = '0;
        r.section = dhkrp_pkg::SEC_NONE;
        if (has) begin
            seen_byte = 1'b1;
            r.out_byte = b;
            // once a record is bad, its bytes are no longer tagged
            if (!rec_error && !gen_bad) begin
                case (phase)
                    PH_PLEN_HI: begin
                        plen = {b, 8'h00};
                        phase = PH_PLEN_LO;
                        r.section = dhkrp_pkg::SEC_PLEN;
                    end
                    PH_PLEN_LO: begin
                        plen[7:0] = b;
                        r.section = dhkrp_pkg::SEC_PLEN;
                        if (special_len()) begin
                            left = plen;
                            spec_id = '0;
                            phase = PH_SPEC;
                        end else if (plen < dhkrp_pkg::MIN_PRIME_LEN) begin
                            rec_error = 1'b1;
                        end else begin
                            left = plen;
                            prime_bits = '0;
                            phase = PH_PRIME;
                        end
                    end
                    PH_SPEC: begin
                        spec_id = {spec_id[7:0], b};
                        left = left - 16'd1;
                        r.section = dhkrp_pkg::SEC_SPEC_ID;
                        if (left == 16'd0) begin
                            phase = PH_GLEN_HI;
                            case (spec_id)
                                ID_P768:  prime_bits = 20'd768;
                                ID_P1024: prime_bits = 20'd1024;
                                ID_P1536: prime_bits = 20'd1536;
                                default: begin
                                    rec_error = 1'b1;
                                    phase = PH_SPEC;
                                end
                            endcase
                        end
                    end
                    PH_PRIME: begin
                        // first nonzero byte fixes the significant bit count
                        if (prime_bits == '0 && b != 8'h00) begin
                            lead = 0;
                            for (i = 0; i < 8; i++)
                                if (b[i]) lead = i + 1;
                            prime_bits = 20'(lead + 8 * (int'(left) - 1));
                        end
                        left = left - 16'd1;
                        r.section = dhkrp_pkg::SEC_PRIME;
                        if (left == 16'd0) phase = PH_GLEN_HI;
                    end
                    PH_GLEN_HI: begin
                        glen = {b, 8'h00};
                        phase = PH_GLEN_LO;
                        r.section = dhkrp_pkg::SEC_GLEN;
                    end
                    PH_GLEN_LO: begin
                        glen[7:0] = b;
                        r.section = dhkrp_pkg::SEC_GLEN;
                        if (special_len()) begin
                            if (glen == 16'd0) begin
                                phase = PH_PUBLEN_HI;
                            end else if (glen == 16'd1) begin
                                left = 16'd1;
                                phase = PH_GEN;
                            end else begin
                                rec_error = 1'b1;
                            end
                        end else if (glen == 16'd0) begin
                            rec_error = 1'b1;
                        end else begin
                            left = glen;
                            phase = PH_GEN;
                        end
                    end
                    PH_GEN: begin
                        if (special_len() && b != SPECIAL_GEN) gen_bad = 1'b1;
                        left = left - 16'd1;
                        r.section = dhkrp_pkg::SEC_GEN;
                        if (left == 16'd0) phase = PH_PUBLEN_HI;
                    end
                    PH_PUBLEN_HI: begin
                        publen = {b, 8'h00};
                        phase = PH_PUBLEN_LO;
                        r.section = dhkrp_pkg::SEC_PUBLEN;
                    end
                    PH_PUBLEN_LO: begin
                        publen[7:0] = b;
                        r.section = dhkrp_pkg::SEC_PUBLEN;
                        if (publen == 16'd0) begin
                            phase = PH_TRAIL;
                        end else begin
                            left = publen;
                            phase = PH_PUB;
                        end
                    end
                    PH_PUB: begin
                        left = left - 16'd1;
                        r.section = dhkrp_pkg::SEC_PUBLIC;
                        if (left == 16'd0) phase = PH_TRAIL;
                    end
                    PH_TRAIL: r.section = dhkrp_pkg::SEC_TRAIL;
                    default: rec_error = 1'b1;
                endcase
            end
        end
        // end of record: status and summary, then back to the start state
        if (last) begin
            r.done_res = 1'b1;
            if (!seen_byte)
                r.status = dhkrp_pkg::ST_EMPTY;
            else if (rec_error || gen_bad || phase != PH_TRAIL)
                r.status = dhkrp_pkg::ST_INVALID;
            else
                r.status = dhkrp_pkg::ST_OK;
            if (r.status == dhkrp_pkg::ST_OK) begin
                r.key_bits      = prime_bits[18:0];
                r.special_prime = special_len() ? spec_id[1:0] : 2'd0;
                r.prime_len     = plen;
                r.gen_len       = glen;
                r.pub_len       = publen;
            end
            clear_parse();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        fail_count++;
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            pending_tags.delete();
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready)
                pending_tags.push_back(parse_item(s_data_byte, s_has_byte, s_last));
            if (m_valid && m_ready) begin
                got.section       = m_section;
                got.out_byte      = m_out_byte;
                got.done_res      = m_done_res;
                got.status        = m_status;
                got.key_bits      = m_key_bits;
                got.special_prime = m_special_prime;
                got.prime_len     = m_prime_len;
                got.gen_len       = m_gen_len;
                got.pub_len       = m_pub_len;
                if (pending_tags.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing pending: %h",
                                              res_count, got));
                end else begin
                    want = pending_tags.pop_front();
                    diff = "";
                    if (got.section != want.section) diff = {diff, " section"};
                    if (got.out_byte != want.out_byte) diff = {diff, " out_byte"};
                    if (got.done_res != want.done_res) diff = {diff, " done_res"};
                    if (got.status != want.status) diff = {diff, " status"};
                    if (got.key_bits != want.key_bits) diff = {diff, " key_bits"};
                    if (got.special_prime != want.special_prime)
                        diff = {diff, " special_prime"};
                    if (got.prime_len != want.prime_len) diff = {diff, " prime_len"};
                    if (got.gen_len != want.gen_len) diff = {diff, " gen_len"};
                    if (got.pub_len != want.pub_len) diff = {diff, " pub_len"};
                    if (diff != "")
                        report_mismatch($sformatf("result %0d:%s wrong, got %h want %h",
                                                  res_count, diff, got, want));
                end
                res_count++;
            end
            outstanding <= pending_tags.size();
        end
    end

endmodule

// ===== bench/dh_key_record_parser_core_test.sv =====
`timescale 1ns / 1ps
// Top of the bench for dh_key_record_parser_core: clock, reset, record stimulus,
// receiver stalls, watchdog and verdict. Depends on the block and on
// dh_key_record_parser_core_check, which does all prediction and comparison.

module dh_key_record_parser_core_test;

    localparam int ITEM_TARGET    = 1440;
    localparam int WATCHDOG_LIMIT = 500;

    // Receiver stall patterns
    typedef enum int {RX_ALWAYS, RX_ALTERNATE, RX_MOSTLY, RX_COIN, RX_LONG_STALL} rx_mode_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [3:0]  m_section;
    wire logic [7:0]  m_out_byte;
    wire logic        m_done_res;
    wire logic [1:0]  m_status;
    wire logic [18:0] m_key_bits;
    wire logic [1:0]  m_special_prime;
    wire logic [15:0] m_prime_len;
    wire logic [15:0] m_gen_len;
    wire logic [15:0] m_pub_len;
    int          fail_count;
    int          outstanding;

    logic [7:0]  rec_bytes[$];
    int          burst_left;
    int          items_sent;
    rx_mode_e    rx_mode;
    int          rx_left;
    int          rx_count;
    int          idle_cycles;

    dh_key_record_parser_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_has_byte(s_has_byte), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_section(m_section),
        .m_out_byte(m_out_byte), .m_done_res(m_done_res), .m_status(m_status),
        .m_key_bits(m_key_bits), .m_special_prime(m_special_prime),
        .m_prime_len(m_prime_len), .m_gen_len(m_gen_len), .m_pub_len(m_pub_len)
    );

    dh_key_record_parser_core_check result_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_has_byte(s_has_byte), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_section(m_section),
        .m_out_byte(m_out_byte), .m_done_res(m_done_res), .m_status(m_status),
        .m_key_bits(m_key_bits), .m_special_prime(m_special_prime),
        .m_prime_len(m_prime_len), .m_gen_len(m_gen_len), .m_pub_len(m_pub_len),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: a new random stall pattern whenever rx_left runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            RX_ALWAYS:     m_ready <= 1'b1;
            RX_ALTERNATE:  m_ready <= rx_count[0];
            RX_MOSTLY:     m_ready <= ($urandom_range(0, 3) != 0);
            RX_COIN:       m_ready <= ($urandom_range(0, 1) == 0);
            default:       m_ready <= ((rx_count % 16) >= 12);
        endcase
    end

    // Watchdog: too long without any transfer on either channel
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("dh_key_record_parser_core: mismatch");
        $finish;
    end

    // One input transfer; bursts of random length with gaps in between
    task automatic send_item(input logic [7:0] b, input logic has, input logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_has_byte <= has;
        s_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    // Hold off input until every pending result is out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic put16(input logic [15:0] v);
        rec_bytes.push_back(v[15:8]);
        rec_bytes.push_back(v[7:0]);
    endtask

    task automatic put_random(input int n);
        repeat (n) rec_bytes.push_back(8'($urandom));
    endtask

    task automatic build_explicit(input logic [15:0] plen, input int zeros,
                                  input logic [15:0] glen, input logic [15:0] publen,
                                  input int trail);
        int i;
        put16(plen);
        for (i = 0; i < int'(plen); i++)
            rec_bytes.push_back((i < zeros) ? 8'h00 : 8'($urandom));
        put16(glen);
        put_random(int'(glen));
        put16(publen);
        put_random(int'(publen));
        put_random(trail);
    endtask

    task automatic build_special(input logic [15:0] idlen, input logic [15:0] id,
                                 input logic [15:0] glen, input logic [7:0] gbyte,
                                 input logic [15:0] publen, input int trail);
        put16(idlen);
        if (idlen == 16'd2) rec_bytes.push_back(id[15:8]);
        rec_bytes.push_back(id[7:0]);
        put16(glen);
        if (glen == 16'd1)
            rec_bytes.push_back(gbyte);
        else
            put_random((glen > 16'd4) ? 4 : int'(glen));
        put16(publen);
        put_random(int'(publen));
        put_random(trail);
    endtask

    // Send the built record; optionally closed by a byte-less end transfer
    task automatic send_record(input bit end_only);
        int n;
        int i;
        bit tail;
        n = rec_bytes.size();
        tail = end_only || (n == 0);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(rec_bytes[i], 1'b1, !tail && (i == n - 1));
        end
        if (tail) send_item(8'($urandom), 1'b0, 1'b1);
        rec_bytes.delete();
    endtask

    task automatic random_record();
        int          kind;
        int          n;
        logic [15:0] plen;
        logic [15:0] v;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(100, 300))
                                            : 16'($urandom_range(16, 24));
        if (kind < 40) begin
            // well-formed explicit prime, sometimes with leading or all zero bytes
            build_explicit(plen, ($urandom_range(0, 9) == 0) ? int'(plen)
                                                             : $urandom_range(0, 2),
                           16'($urandom_range(1, 3)), 16'($urandom_range(0, 6)),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        end else if (kind < 60) begin
            // well-formed special prime; generator byte occasionally wrong
            build_special(16'($urandom_range(1, 2)), 16'($urandom_range(1, 3)),
                          16'($urandom_range(0, 1)),
                          ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd2,
                          16'($urandom_range(0, 6)),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        end else if (kind < 70) begin
            // special prime with an unknown id or an oversized generator
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    v = 16'($urandom_range(0, 255));
                    if (v >= 16'd1 && v <= 16'd3) v = 16'd0;
                    build_special(16'd1, v, 16'd1, 8'd2, 16'd2, 0);
                end else begin
                    v = 16'($urandom);
                    if (v >= 16'd1 && v <= 16'd3) v = 16'h0102;
                    build_special(16'd2, v, 16'd0, 8'd2, 16'd2, 0);
                end
            end else begin
                build_special(16'($urandom_range(1, 2)), 16'($urandom_range(1, 3)),
                              16'($urandom_range(2, 65535)), 8'd2, 16'd1, 0);
            end
        end else if (kind < 80) begin
            // explicit prime rejected: empty generator, short or huge length
            n = $urandom_range(0, 2);
            if (n == 0) begin
                build_explicit(16'd16, 0, 16'd0, 16'd1, 0);
            end else if (n == 1) begin
                v = 16'($urandom_range(0, 15));
                if (v == 16'd1 || v == 16'd2) v = 16'd0;
                put16(v);
                put_random($urandom_range(0, 5));
            end else begin
                put16(16'($urandom_range(300, 65535)));
                put_random($urandom_range(3, 10));
            end
        end else if (kind < 92) begin
            // well-formed record cut short
            if ($urandom_range(0, 1) == 0)
                build_explicit(16'($urandom_range(16, 20)), 0, 16'd1, 16'd2, 0);
            else
                build_special(16'($urandom_range(1, 2)), 16'($urandom_range(1, 3)),
                              16'd1, 8'd2, 16'd3, 0);
            n = $urandom_range(1, rec_bytes.size() - 1);
            repeat (n) void'(rec_bytes.pop_back());
        end else if (kind < 96) begin
            // empty record: rec_bytes stays empty
        end else begin
            put_random($urandom_range(1, 20));
        end
        send_record($urandom_range(0, 4) == 0);
    endtask

    // Stimulus and verdict
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty record
        send_record(1'b1);
        // minimal 768-bit special record
        build_special(16'd1, 16'd1, 16'd0, 8'd2, 16'd0, 0);
        send_record(1'b0);
        // two-byte id, generator 2, public value, trailing byte, end-only close
        build_special(16'd2, 16'd3, 16'd1, 8'd2, 16'd1, 1);
        send_record(1'b1);
        // zero prime length is rejected
        put16(16'h0000);
        send_record(1'b0);
        // maximum prime length, record ends early
        put16(16'hFFFF);
        rec_bytes.push_back(8'hFF);
        send_record(1'b0);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            random_record();
            if ($urandom_range(0, 29) == 0) drain_results();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("dh_key_record_parser_core: match");
        else
            $display("dh_key_record_parser_core: mismatch");
        $finish;
    end

endmodule
